@@ hw/rtl/fpba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and fixed constants of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int FIT_MODE_W = 2;
    localparam int ACTIVE_W   = 5;
    localparam int IN_IDX_W   = 4;
    localparam int IN_SIZE_W  = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_SIZE_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCKS = 2'd1;

    localparam logic [FIT_MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    localparam logic [FIT_MODE_W-1:0] FIT_MODE_RESET      = MODE_FIRST;
    localparam logic [ACTIVE_W-1:0]   ACTIVE_BLOCKS_RESET = 5'd16;

    typedef struct packed {
        logic valid;
        logic is_load;
    } q_ctl_t;

endpackage

@@ hw/rtl/fit_policy_block_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Block allocator with first, best and worst fit placement over a table of
// remaining block sizes.
// ----------------------------------------------------------------------------
// a load occupies the execution side and gives no result
// a request occupies it for a scan of n entries, n = active_blocks capped at MAX_BLOCKS;
// the scan reads one entry per cycle, checks each after the RAM read register, then registers done
// a two-entry command queue lets start be taken while a scan is running
// reset clears the size table to zero through per-entry valid bits, no clearing pass
// results are strobed on done for one cycle; the receiver cannot stall
module fit_policy_block_allocator_top #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic [fpba_pkg::IN_IDX_W-1:0]      block_index,
    input  logic [fpba_pkg::IN_SIZE_W-1:0]     size_value,
    output logic                               done,
    output logic                               granted,
    output logic [fpba_pkg::OUT_IDX_W-1:0]     chosen_block,
    output logic [fpba_pkg::OUT_SIZE_W-1:0]    block_size_before,
    input  logic                               cfg_write,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [fpba_pkg::FIT_MODE_W-1:0] fit_mode_reg;
    logic [fpba_pkg::ACTIVE_W-1:0]   active_blocks_reg;

    fpba_pkg::q_ctl_t     q_ctl;
    logic [IDX_W-1:0]     q_idx;
    logic [SIZE_BITS-1:0] q_size;
    logic [CNT_W-1:0]     q_cnt;
    logic                 q_pop;
    logic [IDX_W-1:0]     chosen_idx;
    logic [SIZE_BITS-1:0] size_before;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg      <= fpba_pkg::FIT_MODE_RESET;
            active_blocks_reg <= fpba_pkg::ACTIVE_BLOCKS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == fpba_pkg::REG_FIT_MODE)
            begin
                fit_mode_reg <= cfg_data[fpba_pkg::FIT_MODE_W-1:0];
            end
            else if (cfg_index == fpba_pkg::REG_ACTIVE_BLOCKS)
            begin
                active_blocks_reg <= cfg_data[fpba_pkg::ACTIVE_W-1:0];
            end
        end
    end

    fpba_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .block_index   (block_index),
        .size_value    (size_value),
        .active_blocks (active_blocks_reg),
        .q_pop         (q_pop),
        .q_ctl         (q_ctl),
        .q_idx         (q_idx),
        .q_size        (q_size),
        .q_cnt         (q_cnt)
    );

    fpba_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fit_mode    (fit_mode_reg),
        .q_ctl       (q_ctl),
        .q_idx       (q_idx),
        .q_size      (q_size),
        .q_cnt       (q_cnt),
        .q_pop       (q_pop),
        .done        (done),
        .granted     (granted),
        .chosen_idx  (chosen_idx),
        .size_before (size_before)
    );

    assign chosen_block      = fpba_pkg::OUT_IDX_W'(chosen_idx);
    assign block_size_before = fpba_pkg::OUT_SIZE_W'(size_before);

`ifndef NO_ASSERTIONS
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !granted |-> (chosen_block == '0) && (block_size_before == '0))
        else $error("refused beat carries nonzero fields");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_ctl.valid)
        else $error("command popped from empty queue");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats back to back");

    a_busy_queue: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> q_ctl.valid)
        else $error("busy with empty queue");
`endif

endmodule

@@ hw/rtl/fpba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fpba_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_front
// Accepts items, drops loads outside the table, resolves the search count
// and holds decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fpba_front #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [fpba_pkg::IN_IDX_W-1:0]    block_index,
    input  logic [fpba_pkg::IN_SIZE_W-1:0]   size_value,
    input  logic [fpba_pkg::ACTIVE_W-1:0]    active_blocks,
    input  logic                             q_pop,
    output fpba_pkg::q_ctl_t                 q_ctl,
    output logic [IDX_W-1:0]                 q_idx,
    output logic [SIZE_BITS-1:0]             q_size,
    output logic [CNT_W-1:0]                 q_cnt
);

    localparam int IW = (CNT_W > fpba_pkg::IN_IDX_W) ? CNT_W : fpba_pkg::IN_IDX_W;
    localparam int CW = (CNT_W > fpba_pkg::ACTIVE_W) ? CNT_W : fpba_pkg::ACTIVE_W;

    logic              accept;
    logic              in_range;
    logic              enq;
    logic [CW-1:0]     act_ext;
    logic [CW-1:0]     max_ext;
    logic [CNT_W-1:0]  cnt_sat;

    logic [1:0]        fill_reg;
    logic [1:0]        fill_next;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;

    logic              ent_load_reg [2];
    logic [IDX_W-1:0]  ent_idx_reg  [2];
    logic [SIZE_BITS-1:0] ent_size_reg [2];
    logic [CNT_W-1:0]  ent_cnt_reg  [2];

    assign busy     = (fill_reg == 2'd2);
    assign accept   = start && !busy;
    assign in_range = (IW'(block_index) < IW'(MAX_BLOCKS));
    assign enq      = accept && ((kind == fpba_pkg::KIND_ALLOC) || in_range);

    assign act_ext = CW'(active_blocks);
    assign max_ext = CW'(MAX_BLOCKS);
    assign cnt_sat = (act_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(act_ext);

    always_comb
    begin
        fill_next = fill_reg;
        if (enq && !q_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!enq && q_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            ent_load_reg[wr_ptr_reg] <= (kind == fpba_pkg::KIND_LOAD);
            ent_idx_reg[wr_ptr_reg]  <= IDX_W'(block_index);
            ent_size_reg[wr_ptr_reg] <= SIZE_BITS'(size_value);
            ent_cnt_reg[wr_ptr_reg]  <= cnt_sat;
        end
    end

    assign q_ctl.valid   = (fill_reg != 2'd0);
    assign q_ctl.is_load = ent_load_reg[rd_ptr_reg];
    assign q_idx         = ent_idx_reg[rd_ptr_reg];
    assign q_size        = ent_size_reg[rd_ptr_reg];
    assign q_cnt         = ent_cnt_reg[rd_ptr_reg];

endmodule

@@ hw/rtl/fpba_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_back
// Executes queued commands: writes block sizes, scans the table one entry
// per cycle for the fitting block, then updates it if one fits and issues the result.
// ----------------------------------------------------------------------------
module fpba_back #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fpba_pkg::FIT_MODE_W-1:0]   fit_mode,
    input  fpba_pkg::q_ctl_t                  q_ctl,
    input  logic [IDX_W-1:0]                  q_idx,
    input  logic [SIZE_BITS-1:0]              q_size,
    input  logic [CNT_W-1:0]                  q_cnt,
    output logic                              q_pop,
    output logic                              done,
    output logic                              granted,
    output logic [IDX_W-1:0]                  chosen_idx,
    output logic [SIZE_BITS-1:0]              size_before
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CNT_W-1:0]     issue_reg;
    logic [CNT_W-1:0]     issue_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic                 chk_valid_reg;
    logic                 chk_valid_next;
    logic                 chk_hit_reg;
    logic [IDX_W-1:0]     chk_idx_reg;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [SIZE_BITS-1:0] best_val_reg;
    logic [SIZE_BITS-1:0] best_val_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 granted_reg;
    logic [IDX_W-1:0]     chosen_reg;
    logic [SIZE_BITS-1:0] before_reg;
    logic [MAX_BLOCKS-1:0] valid_reg;

    logic                 issuing;
    logic                 finish;
    logic [SIZE_BITS-1:0] have;
    logic                 take;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_pop     = (state_reg == ST_IDLE) && q_ctl.valid;
    assign issuing   = (state_reg == ST_SCAN) && (issue_reg < cnt_reg);
    assign finish    = (state_reg == ST_SCAN) && !issuing && !chk_valid_reg;
    assign ram_raddr = issue_reg[IDX_W-1:0];
    assign have      = chk_hit_reg ? ram_rdata : '0;

    always_comb
    begin
        take = 1'b0;
        if (chk_valid_reg && (req_reg <= have))
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (fit_mode == fpba_pkg::MODE_BEST)
            begin
                take = (have < best_val_reg);
            end
            else if (fit_mode == fpba_pkg::MODE_WORST)
            begin
                take = (have > best_val_reg);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        done_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = q_idx;
        ram_wdata      = q_size;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_ctl.valid)
                begin
                    if (q_ctl.is_load)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        issue_next = '0;
                        found_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    chk_valid_next = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                end
                if (take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = chk_idx_reg;
                    best_val_next = have;
                end
                if (finish)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ram_we     = found_reg;
                    ram_waddr  = best_idx_reg;
                    ram_wdata  = best_val_reg - req_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cnt_reg <= q_cnt;
            req_reg <= q_size;
        end
        chk_hit_reg  <= valid_reg[ram_raddr];
        chk_idx_reg  <= ram_raddr;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        if (finish)
        begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? best_idx_reg : '0;
            before_reg  <= found_reg ? best_val_reg : '0;
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign chosen_idx  = chosen_reg;
    assign size_before = before_reg;

endmodule
